// ===== rtl/s8dfc_pkg.sv =====
// Shared types and constants for the sum8 delimited frame checker.
package s8dfc_pkg;

    localparam logic [7:0] START_MARK  = 8'h40;
    localparam logic [7:0] EQUALS_MARK = 8'h3D;
    localparam logic [7:0] END_MARK    = 8'h23;
    localparam logic [9:0] FRAME_OVERHEAD = 10'd6;
    localparam int unsigned POS_W = 9;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef enum logic [1:0] {
        ST_GOOD       = 2'd0,
        ST_MARKER_ERR = 2'd1,
        ST_LENGTH_ERR = 2'd2,
        ST_CHECK_ERR  = 2'd3
    } t_status;

    typedef struct packed {
        t_status    status;
        logic [7:0] format_number;
        logic [7:0] payload_length;
    } t_result;

endpackage

// ===== rtl/s8dfc_byte_if.sv =====
// Frame byte channel: valid, ready, data byte and final-byte flag.
interface s8dfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_end;

    modport source (output valid, output data_byte, output frame_end, input ready);
    modport sink   (input valid, input data_byte, input frame_end, output ready);
endinterface

// ===== rtl/s8dfc_res_if.sv =====
// Result channel: valid, ready, status and captured header bytes.
interface s8dfc_res_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] format_number;
    logic [7:0] payload_length;

    modport source (output valid, output status, output format_number,
                    output payload_length, input ready);
    modport sink   (input valid, input status, input format_number,
                    input payload_length, output ready);
endinterface

// ===== rtl/s8dfc_cfg_if.sv =====
// Configuration write channel: valid, ready and write data.
interface s8dfc_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/sum8_delimited_frame_checker.sv =====
// Top level of the sum8 delimited frame checker.
//
// Channels: i_in carries frame bytes with a final-byte flag, o_res carries
// one status per frame, i_cfg writes the highest accepted format number.
// A frame is '@', format, length, '=', payload, checksum, '#'.
// Status 0 good, 1 marker error or short frame, 2 length mismatch,
// 3 format above limit or checksum mismatch.
// Throughput: one byte per cycle while no result waits unaccepted; the per-byte work is a compare and an
// 8-bit add on the frame state registers.
// Latency: the result appears in the cycle after the final byte transfer,
// held in a single result register.
// Stall: while a result waits unaccepted, i_in.ready drops; it rises again
// in the cycle the receiver takes the result, so bytes keep flowing.
// Reset: clears the frame state, drops the pending result and sets the
// format limit to zero. i_cfg is always ready.
module sum8_delimited_frame_checker
    import s8dfc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    s8dfc_byte_if.sink   i_in,
    s8dfc_cfg_if.sink    i_cfg,
    s8dfc_res_if.source  o_res
);

    logic [7:0] r_highest_format;
    logic       accept;
    logic       done;
    logic       free;
    t_result    calc_result;
    t_result    held_result;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = free;
    assign accept      = i_in.valid && free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_highest_format <= '0;
        end else if (i_cfg.valid) begin
            r_highest_format <= i_cfg.data;
        end
    end

    s8dfc_tracker u_tracker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_data_byte      (i_in.data_byte),
        .i_frame_end      (i_in.frame_end),
        .i_highest_format (r_highest_format),
        .o_done           (done),
        .o_result         (calc_result)
    );

    s8dfc_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (done),
        .i_result (calc_result),
        .i_ready  (o_res.ready),
        .o_valid  (o_res.valid),
        .o_free   (free),
        .o_result (held_result)
    );

    assign o_res.status         = held_result.status;
    assign o_res.format_number  = held_result.format_number;
    assign o_res.payload_length = held_result.payload_length;

    a_final_byte_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && i_in.frame_end) |=> o_res.valid)
        else $error("final byte transfer did not produce a result");

    a_no_result_from_mid_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready && !i_in.frame_end) |=> !o_res.valid)
        else $error("result produced without a final byte");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_in.ready)
        else $error("input taken while result is stalled");

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_res.valid)
        else $error("result valid after reset");

endmodule

// ===== rtl/s8dfc_tracker.sv =====
// Per-frame state registers and status evaluation at the final byte.
module s8dfc_tracker
    import s8dfc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_data_byte,
    input  logic          i_frame_end,
    input  logic [7:0]    i_highest_format,
    output logic          o_done,
    output t_result       o_result
);

    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_start_ok, n_start_ok;
    logic             r_equals_ok, n_equals_ok;
    logic [7:0]       r_format, n_format;
    logic [7:0]       r_length, n_length;
    logic [7:0]       r_sum, n_sum;
    logic [7:0]       r_prev, n_prev;
    logic [7:0]       r_prev2, n_prev2;
    logic [9:0]       frame_len;
    logic [9:0]       claimed_len;

    always_comb begin
        n_start_ok  = (r_pos == POS_W'(0)) ? (i_data_byte == START_MARK) : r_start_ok;
        n_format    = (r_pos == POS_W'(1)) ? i_data_byte : r_format;
        n_length    = (r_pos == POS_W'(2)) ? i_data_byte : r_length;
        n_equals_ok = (r_pos == POS_W'(3)) ? (i_data_byte == EQUALS_MARK) : r_equals_ok;
        n_sum       = (r_pos >= POS_W'(6)) ? r_sum + r_prev2 : r_sum;
        n_prev      = i_data_byte;
        n_prev2     = r_prev;
        n_pos       = (r_pos == POS_MAX) ? POS_MAX : r_pos + POS_W'(1);

        frame_len   = {1'b0, r_pos} + 10'd1;
        claimed_len = {2'b00, n_length} + FRAME_OVERHEAD;

        o_done                  = i_accept && i_frame_end;
        o_result.format_number  = n_format;
        o_result.payload_length = n_length;
        if (r_pos < POS_W'(3) || !n_start_ok || !n_equals_ok || i_data_byte != END_MARK) begin
            o_result.status = ST_MARKER_ERR;
        end else if (frame_len != claimed_len) begin
            o_result.status = ST_LENGTH_ERR;
        end else if (n_format > i_highest_format || n_sum != r_prev) begin
            o_result.status = ST_CHECK_ERR;
        end else begin
            o_result.status = ST_GOOD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_start_ok  <= 1'b0;
            r_equals_ok <= 1'b0;
            r_format    <= '0;
            r_length    <= '0;
            r_sum       <= '0;
            r_prev      <= '0;
            r_prev2     <= '0;
        end else if (i_accept) begin
            if (i_frame_end) begin
                r_pos       <= '0;
                r_start_ok  <= 1'b0;
                r_equals_ok <= 1'b0;
                r_format    <= '0;
                r_length    <= '0;
                r_sum       <= '0;
                r_prev      <= '0;
                r_prev2     <= '0;
            end else begin
                r_pos       <= n_pos;
                r_start_ok  <= n_start_ok;
                r_equals_ok <= n_equals_ok;
                r_format    <= n_format;
                r_length    <= n_length;
                r_sum       <= n_sum;
                r_prev      <= n_prev;
                r_prev2     <= n_prev2;
            end
        end
    end

endmodule

// ===== rtl/s8dfc_out_reg.sv =====
// Result register with valid/ready handshake toward the receiver.
module s8dfc_out_reg
    import s8dfc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_ready,
    output logic    o_valid,
    output logic    o_free,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench for the sum8 delimited frame checker: predicted frame statuses against DUT results.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import s8dfc_pkg::*;

    class frame_check_scoreboard;
        logic [7:0]       format_limit;
        logic [POS_W-1:0] position;
        logic             start_ok;
        logic             equals_ok;
        logic [7:0]       format_byte;
        logic [7:0]       length_byte;
        logic [7:0]       payload_sum;
        logic [7:0]       last_byte;
        logic [7:0]       byte_before_last;
        t_result          expected_status[$];
        int               mismatches;

        function new();
            format_limit = 8'd0;
            mismatches   = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            position         = '0;
            start_ok         = 1'b0;
            equals_ok        = 1'b0;
            format_byte      = 8'd0;
            length_byte      = 8'd0;
            payload_sum      = 8'd0;
            last_byte        = 8'd0;
            byte_before_last = 8'd0;
        endfunction

        function void set_limit(logic [7:0] value);
            format_limit = value;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void note_byte(logic [7:0] d, logic last);
            t_result r;
            t_status st;
            if (position >= POS_W'(FRAME_OVERHEAD))
                payload_sum = payload_sum + byte_before_last;
            if (position == 0) start_ok  = (d == START_MARK);
            if (position == 1) format_byte = d;
            if (position == 2) length_byte = d;
            if (position == 3) equals_ok = (d == EQUALS_MARK);
            if (!last) begin
                byte_before_last = last_byte;
                last_byte        = d;
                if (position != POS_MAX) position = position + POS_W'(1);
                return;
            end
            if (position < 3 || !start_ok || !equals_ok || d != END_MARK)
                st = ST_MARKER_ERR;
            else if (10'(position) + 10'd1 != 10'(length_byte) + FRAME_OVERHEAD)
                st = ST_LENGTH_ERR;
            else if (format_byte > format_limit || payload_sum != last_byte)
                st = ST_CHECK_ERR;
            else
                st = ST_GOOD;
            r.status         = st;
            r.format_number  = format_byte;
            r.payload_length = length_byte;
            expected_status.push_back(r);
            clear_frame();
        endfunction

        function void check_status(logic [1:0] st, logic [7:0] fmt, logic [7:0] len);
            t_result exp;
            if (expected_status.size() == 0) begin
                $error("result with no frame pending: status %0d", st);
                mismatches++;
                return;
            end
            exp = expected_status.pop_front();
            if (st !== exp.status) begin
                $error("status mismatch: expected %0d actual %0d", exp.status, st);
                mismatches++;
            end
            if (fmt !== exp.format_number) begin
                $error("format_number mismatch: expected %0d actual %0d",
                       exp.format_number, fmt);
                mismatches++;
            end
            if (len !== exp.payload_length) begin
                $error("payload_length mismatch: expected %0d actual %0d",
                       exp.payload_length, len);
                mismatches++;
            end
        endfunction
    endclass

    localparam int QUIET_LIMIT  = 5000;
    localparam int PHASE_BYTES  = 250;
    localparam int NUM_PHASES   = 6;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    s8dfc_byte_if in_if();
    s8dfc_cfg_if  cfg_if();
    s8dfc_res_if  res_if();

    sum8_delimited_frame_checker i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    frame_check_scoreboard sb;
    logic [7:0] frame_bytes[$];
    logic [7:0] current_limit;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         quiet_cycles;
    bit         moved;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            moved = 1'b0;
            if (cfg_if.valid && cfg_if.ready) begin
                sb.set_limit(cfg_if.data);
                moved = 1'b1;
            end
            if (res_if.valid && res_if.ready) begin
                sb.check_status(res_if.status, res_if.format_number, res_if.payload_length);
                moved = 1'b1;
            end
            if (in_if.valid && in_if.ready) begin
                sb.note_byte(in_if.data_byte, in_if.frame_end);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin
        @(posedge i_rst_n);
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    task automatic send_byte(input logic [7:0] d, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.data_byte <= d;
        in_if.frame_end <= last;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    // hold the sender until every pending status has been taken
    task automatic settle();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [7:0] value);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        current_limit = value;
    endtask

    function automatic void make_frame(input int plen, input logic [7:0] fmt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = 8'd0;
        frame_bytes.delete();
        frame_bytes.push_back(START_MARK);
        frame_bytes.push_back(fmt);
        frame_bytes.push_back(8'(plen));
        frame_bytes.push_back(EQUALS_MARK);
        repeat (plen) begin
            b = 8'($urandom);
            sum = sum + b;
            frame_bytes.push_back(b);
        end
        frame_bytes.push_back(sum);
        frame_bytes.push_back(END_MARK);
    endfunction

    task automatic run_random(input int budget, input bit force_long, input bit force_max);
        int         sent;
        int         plen;
        int         kind;
        int         cut;
        int         last_idx;
        bit         first;
        logic [7:0] fmt;
        sent  = 0;
        first = 1'b1;
        while (sent < budget) begin
            plen = ($urandom_range(99) < 3) ? $urandom_range(13, 255) : $urandom_range(0, 12);
            fmt  = ($urandom_range(3) == 0) ? 8'($urandom)
                                            : 8'($urandom_range(0, int'(current_limit)));
            if (first && force_long) plen = 520;
            if (first && force_max) begin
                plen = 255;
                fmt  = current_limit;
            end
            make_frame(plen, fmt);
            last_idx = frame_bytes.size() - 1;
            kind = $urandom_range(99);
            if (!first && kind >= 85) begin
                frame_bytes.delete();
                repeat ($urandom_range(1, 8)) frame_bytes.push_back(8'($urandom));
                if ($urandom_range(1) == 1) frame_bytes[0] = START_MARK;
            end else if (!first && kind >= 55) begin
                case ($urandom_range(0, 7))
                    0: frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
                    1: frame_bytes[1] = 8'($urandom);
                    2: frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
                    3: frame_bytes[3] = frame_bytes[3] ^ 8'($urandom_range(1, 255));
                    4: frame_bytes[last_idx-1] = frame_bytes[last_idx-1]
                                                 ^ 8'($urandom_range(1, 255));
                    5: frame_bytes[last_idx] = frame_bytes[last_idx]
                                               ^ 8'($urandom_range(1, 255));
                    6: begin
                        cut = $urandom_range(1, last_idx);
                        while (frame_bytes.size() > cut) void'(frame_bytes.pop_back());
                    end
                    default: repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
                endcase
            end
            first = 1'b0;
            send_frame();
            sent += frame_bytes.size();
            if ($urandom_range(99) < 2) settle();
        end
    endtask

    initial begin
        int ph;
        sb               = new();
        current_limit    = 8'd0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        quiet_cycles     = 0;
        in_if.valid      = 1'b0;
        in_if.data_byte  = 8'd0;
        in_if.frame_end  = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.data      = 8'd0;
        res_if.ready     = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        frame_bytes = '{START_MARK, 8'h00, 8'h00, EQUALS_MARK, 8'h00, END_MARK};
        send_frame();
        frame_bytes = '{8'hFF};
        send_frame();
        frame_bytes = '{START_MARK, 8'h00, 8'h00, EQUALS_MARK, 8'h01, END_MARK};
        send_frame();
        frame_bytes = '{START_MARK, 8'hFF, 8'h01, EQUALS_MARK, 8'hFF, 8'hFF, END_MARK};
        send_frame();
        frame_bytes = '{START_MARK, 8'h00, 8'h02, EQUALS_MARK, 8'h01, 8'h01, END_MARK};
        send_frame();

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle();
            if (ph == 0 || ph == 3)
                write_limit(8'hFF);
            else if (ph == 1 || ph == 5)
                write_limit(8'h00);
            else
                write_limit(8'($urandom_range(0, 255)));
            send_idle_pct  = (ph % 4 == 1) ? 66 : (ph % 4 == 3) ? 22 : 0;
            recv_stall_pct = (ph % 4 == 2) ? 66 : (ph % 4 == 3) ? 22 : 0;
            run_random(PHASE_BYTES, ph == 1, ph == 3);
        end

        settle();
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0) begin
            $error("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

// ===== sum8_delimited_frame_checker.f =====
rtl/s8dfc_pkg.sv
rtl/s8dfc_byte_if.sv
rtl/s8dfc_res_if.sv
rtl/s8dfc_cfg_if.sv
rtl/s8dfc_tracker.sv
rtl/s8dfc_out_reg.sv
rtl/sum8_delimited_frame_checker.sv
sim/tb.sv
